/* rtl/core/two_pole_lowpass_multichannel_macros.svh */
// assertion macros for the two-pole low-pass filter block
// expects clk and rst_n in the scope of each use
`ifndef TWO_POLE_LOWPASS_MULTICHANNEL_MACROS_SVH
`define TWO_POLE_LOWPASS_MULTICHANNEL_MACROS_SVH

// same-cycle implication
`define TPLP_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tplp assertion failed");

// next-cycle implication
`define TPLP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tplp assertion failed");

`endif

/* rtl/core/tplp_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths, codes and saturation helpers of the two-pole low-pass filter
// no dependencies
package tplp_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_W    = 16;
    localparam int HIST_W      = SAMPLE_W + 8;
    localparam int CHAN_W      = 3;
    localparam int SUM_W       = 18;
    localparam int PROD_W      = 17;
    localparam int CIU_W       = 4;
    localparam int GAIN_W      = 20;
    localparam int CFG_DATA_W  = 18;
    localparam int REG_IDX_W   = 2;

    localparam int XQ_SH       = 8;
    localparam int ROUND_SH    = 16;
    localparam int OUT_SH      = 8;
    localparam int PROD_GX_W   = GAIN_W + SAMPLE_W;
    localparam int PROD_SY_W   = SUM_W + 1 + HIST_W;
    localparam int PROD_PY_W   = PROD_W + 1 + HIST_W;
    localparam int ACC_W       = PROD_SY_W + 3;
    localparam int HIST_WIDE_W = ACC_W - ROUND_SH;
    localparam int OUT_WIDE_W  = HIST_W + 1 - OUT_SH;

    localparam logic [SUM_W-1:0]         COEF_SUM_RST  = SUM_W'(118599);
    localparam logic [PROD_W-1:0]        COEF_PROD_RST = PROD_W'(53656);
    localparam logic [CIU_W-1:0]         CIU_RST       = CIU_W'(1);
    localparam logic signed [GAIN_W-1:0] GAIN_ONE      = GAIN_W'(65536);
    localparam logic signed [GAIN_W-1:0] GAIN_RST      =
        GAIN_ONE - GAIN_W'(COEF_SUM_RST) + GAIN_W'(COEF_PROD_RST);
    localparam logic signed [ACC_W-1:0]  ACC_HALF      = ACC_W'(1) << (ROUND_SH - 1);
    localparam logic signed [HIST_W:0]   HIST_HALF     = (HIST_W + 1)'(1) << (OUT_SH - 1);
    localparam logic [CIU_W-1:0]         CH_LIMIT      = CIU_W'(CHANNELS);

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        STATUS_OK          = 1'b0,
        STATUS_BAD_CHANNEL = 1'b1
    } status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_SUM        = 2'd0,
        REG_COEF_PROD       = 2'd1,
        REG_CHANNELS_IN_USE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0]         coef_sum;
        logic [PROD_W-1:0]        coef_prod;
        logic [CIU_W-1:0]         channels_in_use;
        logic signed [GAIN_W-1:0] gain;
    } tplp_cfg_t;

    typedef struct packed {
        logic [HIST_W-1:0] prior;
        logic [HIST_W-1:0] older;
    } hist_pair_t;

    function automatic logic [HIST_W-1:0] sat_hist(input logic [HIST_WIDE_W-1:0] v);
        logic [HIST_WIDE_W-HIST_W:0] upper;
        upper = v[HIST_WIDE_W-1:HIST_W-1];
        if (upper == '0 || upper == '1)
        begin
            return v[HIST_W-1:0];
        end
        return v[HIST_WIDE_W-1] ? {1'b1, {(HIST_W - 1){1'b0}}}
                                : {1'b0, {(HIST_W - 1){1'b1}}};
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [OUT_WIDE_W-1:0] v);
        logic [OUT_WIDE_W-SAMPLE_W:0] upper;
        upper = v[OUT_WIDE_W-1:SAMPLE_W-1];
        if (upper == '0 || upper == '1)
        begin
            return v[SAMPLE_W-1:0];
        end
        return v[OUT_WIDE_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                               : {1'b0, {(SAMPLE_W - 1){1'b1}}};
    endfunction

endpackage

/* rtl/core/tplp_intf.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: sample items, results, register writes
// depends on tplp_pkg
interface tplp_item_if import tplp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    opcode_t                    opcode;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, opcode, channel, sample, input ready);
    modport sink   (input valid, opcode, channel, sample, output ready);
endinterface

interface tplp_result_if import tplp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_value;
    status_t                    status;
    logic [CHAN_W-1:0]          channel_echo;

    modport source (output valid, filtered_value, status, channel_echo, input ready);
    modport sink   (input valid, filtered_value, status, channel_echo, output ready);
endinterface

interface tplp_cfg_if import tplp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/two_pole_lowpass_multichannel.sv */
`timescale 1ns / 1ps
// Multichannel two-pole low-pass filter, y = (1 - s + p)*x + s*y1 - p*y2 per channel.
// Each channel's last two outputs live in one history memory with a registered
// read; an item reads it when accepted, forms the three products in the next
// cycle in the products stage, then sums, rounds and saturates in the accumulate
// stage, which writes the history back and loads the result register. Items on
// different channels are taken one per cycle while the output is not stalled. A
// sample for the same channel as the sample right before it waits while that
// sample is in the products stage, because the new output must pass through the
// products stage before it can feed the next one. A clear takes effect in order
// through per-channel valid bits; no clearing pass is needed. A result waiting
// on the output holds the input back only once both stages behind it are full,
// or for a sample on the channel still in the accumulate stage.
// Depends on tplp_pkg, tplp_intf, tplp_cfg_regs and the macros header.
`include "two_pole_lowpass_multichannel_macros.svh"

module two_pole_lowpass_multichannel import tplp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tplp_item_if.sink     item,
    tplp_result_if.source result,
    tplp_cfg_if.sink      cfg
);

    tplp_cfg_t regs;

    tplp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // history memory
    hist_pair_t hist_mem [CHANNELS];
    hist_pair_t rd_data_reg;
    hist_pair_t wr_data;
    logic       mem_we;

    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] valid_next;
    logic                fwd_hit_reg;
    hist_pair_t          fwd_data_reg;

    // read stage
    logic                       s1_valid_reg;
    opcode_t                    s1_op_reg;
    logic [CHAN_W-1:0]          s1_ch_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic                       s1_err_reg;
    logic                       s1_wr;
    hist_pair_t                 hist_sel;
    logic signed [PROD_GX_W-1:0] prod_gx;
    logic signed [PROD_SY_W-1:0] prod_sy;
    logic signed [PROD_PY_W-1:0] prod_py;

    // accumulate stage
    logic                        s2_valid_reg;
    opcode_t                     s2_op_reg;
    logic [CHAN_W-1:0]           s2_ch_reg;
    logic                        s2_err_reg;
    logic                        s2_wr;
    logic [HIST_W-1:0]           s2_prior_reg;
    logic signed [PROD_GX_W-1:0] s2_gx_reg;
    logic signed [PROD_SY_W-1:0] s2_sy_reg;
    logic signed [PROD_PY_W-1:0] s2_py_reg;
    logic signed [PROD_GX_W+XQ_SH-1:0] gx_term;
    logic signed [ACC_W-1:0]     acc;
    logic [HIST_W-1:0]           hist_new;
    logic signed [HIST_W:0]      out_sum;
    logic [SAMPLE_W-1:0]         y_sat;

    // result register
    logic                        out_valid_reg;
    logic [SAMPLE_W-1:0]         out_value_reg;
    status_t                     out_status_reg;
    logic [CHAN_W-1:0]           out_ch_reg;

    logic en_out;
    logic en_s2;
    logic en_s1;
    logic hazard;
    logic accept;
    logic in_err;
    logic s1_live_wr;
    logic s2_live_wr;
    logic clear_go;

    assign en_out = !out_valid_reg || result.ready;
    assign en_s2  = !s2_valid_reg || en_out;
    assign en_s1  = !s1_valid_reg || en_s2;

    assign s1_wr = (s1_op_reg == OP_SAMPLE) && !s1_err_reg;
    assign s2_wr = (s2_op_reg == OP_SAMPLE) && !s2_err_reg;

    assign s1_live_wr = s1_valid_reg && s1_wr;
    assign s2_live_wr = s2_valid_reg && s2_wr;
    assign clear_go   = s2_valid_reg && en_out && (s2_op_reg == OP_CLEAR);

    // same channel still in the products stage, or history not yet written back
    assign hazard = (item.opcode == OP_SAMPLE)
                 && ((s1_live_wr && (s1_ch_reg == item.channel))
                  || (s2_live_wr && (s2_ch_reg == item.channel) && !en_out));

    assign item.ready = en_s1 && !hazard;
    assign accept     = item.valid && item.ready;

    assign in_err = (item.opcode == OP_SAMPLE)
                 && (({1'b0, item.channel} >= regs.channels_in_use)
                  || ({1'b0, item.channel} >= CH_LIMIT));

    assign mem_we = s2_live_wr && en_out;

    // memory ports
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= hist_mem[item.channel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[s2_ch_reg] <= wr_data;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear_go)
        begin
            valid_next = '0;
        end
        else if (mem_we)
        begin
            valid_next[s2_ch_reg] = 1'b1;
        end
    end

    // products stage
    always_comb
    begin
        if (s2_valid_reg && (s2_op_reg == OP_CLEAR))
        begin
            hist_sel = '0;
        end
        else if (fwd_hit_reg)
        begin
            hist_sel = fwd_data_reg;
        end
        else if (valid_reg[s1_ch_reg])
        begin
            hist_sel = rd_data_reg;
        end
        else
        begin
            hist_sel = '0;
        end
    end

    assign prod_gx = PROD_GX_W'(regs.gain) * PROD_GX_W'(s1_x_reg);
    assign prod_sy = PROD_SY_W'($signed({1'b0, regs.coef_sum}))
                   * PROD_SY_W'($signed(hist_sel.prior));
    assign prod_py = PROD_PY_W'($signed({1'b0, regs.coef_prod}))
                   * PROD_PY_W'($signed(hist_sel.older));

    // accumulate, round and saturate
    assign gx_term  = $signed({s2_gx_reg, {XQ_SH{1'b0}}});
    assign acc      = ACC_W'(gx_term) + ACC_W'(s2_sy_reg) - ACC_W'(s2_py_reg) + ACC_HALF;
    assign hist_new = sat_hist(acc[ACC_W-1:ROUND_SH]);
    assign out_sum  = $signed({hist_new[HIST_W-1], hist_new}) + HIST_HALF;
    assign y_sat    = sat_sample(out_sum[HIST_W:OUT_SH]);

    assign wr_data.prior = hist_new;
    assign wr_data.older = s2_prior_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                fwd_hit_reg <= mem_we && (s2_ch_reg == item.channel);
            end
            if (en_s1)
            begin
                s1_valid_reg <= accept;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
            s1_op_reg    <= item.opcode;
            s1_ch_reg    <= item.channel;
            s1_x_reg     <= item.sample;
            s1_err_reg   <= in_err;
        end
        if (en_s2 && s1_valid_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_err_reg   <= s1_err_reg;
            s2_prior_reg <= hist_sel.prior;
            s2_gx_reg    <= prod_gx;
            s2_sy_reg    <= prod_sy;
            s2_py_reg    <= prod_py;
        end
        if (en_out && s2_valid_reg)
        begin
            out_value_reg  <= s2_wr ? y_sat : '0;
            out_status_reg <= s2_err_reg ? STATUS_BAD_CHANNEL : STATUS_OK;
            out_ch_reg     <= s2_ch_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.filtered_value = $signed(out_value_reg);
    assign result.status         = out_status_reg;
    assign result.channel_echo   = out_ch_reg;

    `TPLP_ASSERT_IMPL(a_no_dual_writer, s1_live_wr && s2_live_wr, s1_ch_reg != s2_ch_reg)
    `TPLP_ASSERT_NEXT(a_clear_empties, clear_go, valid_reg == '0)
    `TPLP_ASSERT_NEXT(a_s2_reaches_out, s2_valid_reg && en_out, result.valid)

endmodule

/* rtl/core/tplp_cfg_regs.sv */
`timescale 1ns / 1ps
// configuration registers of the filter, with the input gain kept precomputed
// depends on tplp_pkg and tplp_intf
module tplp_cfg_regs import tplp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tplp_cfg_if.sink   cfg,
    output tplp_cfg_t  regs
);

    logic [SUM_W-1:0]         coef_sum_reg;
    logic [SUM_W-1:0]         coef_sum_next;
    logic [PROD_W-1:0]        coef_prod_reg;
    logic [PROD_W-1:0]        coef_prod_next;
    logic [CIU_W-1:0]         ciu_reg;
    logic [CIU_W-1:0]         ciu_next;
    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [GAIN_W-1:0] gain_next;
    logic                     wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_comb
    begin
        coef_sum_next  = coef_sum_reg;
        coef_prod_next = coef_prod_reg;
        ciu_next       = ciu_reg;
        gain_next      = gain_reg;
        if (wr_en)
        begin
            case (reg_index_t'(cfg.index))
                REG_COEF_SUM:
                begin
                    coef_sum_next = cfg.data[SUM_W-1:0];
                    gain_next     = GAIN_ONE - GAIN_W'(cfg.data[SUM_W-1:0])
                                  + GAIN_W'(coef_prod_reg);
                end
                REG_COEF_PROD:
                begin
                    coef_prod_next = cfg.data[PROD_W-1:0];
                    gain_next      = GAIN_ONE - GAIN_W'(coef_sum_reg)
                                   + GAIN_W'(cfg.data[PROD_W-1:0]);
                end
                REG_CHANNELS_IN_USE:
                begin
                    ciu_next = cfg.data[CIU_W-1:0];
                end
                default:
                begin
                    ciu_next = ciu_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_sum_reg  <= COEF_SUM_RST;
            coef_prod_reg <= COEF_PROD_RST;
            ciu_reg       <= CIU_RST;
            gain_reg      <= GAIN_RST;
        end
        else
        begin
            coef_sum_reg  <= coef_sum_next;
            coef_prod_reg <= coef_prod_next;
            ciu_reg       <= ciu_next;
            gain_reg      <= gain_next;
        end
    end

    assign regs.coef_sum        = coef_sum_reg;
    assign regs.coef_prod       = coef_prod_reg;
    assign regs.channels_in_use = ciu_reg;
    assign regs.gain            = gain_reg;

endmodule

/* tb/two_pole_lowpass_multichannel_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the two-pole low-pass filter: directed and random samples,
// register settings, random idling on both sides, in-order output scoreboard
// depends on tplp_pkg, tplp_intf and the two_pole_lowpass_multichannel rtl
module two_pole_lowpass_multichannel_tb import tplp_pkg::*;
();

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_value;
        status_t                    status;
        logic [CHAN_W-1:0]          channel_echo;
    } filter_output_t;

    class lowpass_scoreboard;
        logic [SUM_W-1:0]         coef_sum;
        logic [PROD_W-1:0]        coef_prod;
        logic [CIU_W-1:0]         chans_in_use;
        logic signed [HIST_W-1:0] prior_hist [CHANNELS];
        logic signed [HIST_W-1:0] older_hist [CHANNELS];
        filter_output_t           awaited_outputs [$];
        int unsigned              failures;

        function new();
            coef_sum = COEF_SUM_RST;
            coef_prod = COEF_PROD_RST;
            chans_in_use = CIU_RST;
            failures = 0;
            clear_history();
        endfunction

        function void clear_history();
            for (int i = 0; i < CHANNELS; i++)
            begin
                prior_hist[i] = '0;
                older_hist[i] = '0;
            end
        endfunction

        function longint clamp(longint v, int bits);
            longint top;
            top = (longint'(1) <<< (bits - 1)) - 1;
            if (v > top)
            begin
                return top;
            end
            if (v < -top - 1)
            begin
                return -top - 1;
            end
            return v;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_COEF_SUM:        coef_sum = value[SUM_W-1:0];
                REG_COEF_PROD:       coef_prod = value[PROD_W-1:0];
                REG_CHANNELS_IN_USE: chans_in_use = value[CIU_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_item(opcode_t op, logic [CHAN_W-1:0] ch,
                                   logic signed [SAMPLE_W-1:0] x);
            filter_output_t res;
            longint gain;
            longint acc;
            longint hist;
            res.filtered_value = '0;
            res.status = STATUS_OK;
            res.channel_echo = ch;
            if (op == OP_CLEAR)
            begin
                clear_history();
            end
            else if (int'(ch) >= int'(chans_in_use) || int'(ch) >= CHANNELS)
            begin
                res.status = STATUS_BAD_CHANNEL;
            end
            else
            begin
                gain = 65536 - longint'(coef_sum) + longint'(coef_prod);
                acc = gain * (longint'(x) * 256)
                    + longint'(coef_sum) * longint'(prior_hist[ch])
                    - longint'(coef_prod) * longint'(older_hist[ch]);
                hist = clamp((acc + 32768) >>> 16, HIST_W);
                older_hist[ch] = prior_hist[ch];
                prior_hist[ch] = HIST_W'(hist);
                res.filtered_value = SAMPLE_W'(clamp((hist + 128) >>> 8, SAMPLE_W));
            end
            awaited_outputs.push_back(res);
        endfunction

        function void compare_output(logic signed [SAMPLE_W-1:0] fv, status_t st,
                                     logic [CHAN_W-1:0] ch);
            filter_output_t want;
            if (awaited_outputs.size() == 0)
            begin
                $error("unexpected result: filtered_value %0d status %0d channel_echo %0d",
                       fv, st, ch);
                failures++;
                return;
            end
            want = awaited_outputs.pop_front();
            if (fv !== want.filtered_value)
            begin
                $error("filtered_value expected %0d actual %0d", want.filtered_value, fv);
                failures++;
            end
            if (st !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, st);
                failures++;
            end
            if (ch !== want.channel_echo)
            begin
                $error("channel_echo expected %0d actual %0d", want.channel_echo, ch);
                failures++;
            end
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tplp_item_if   item_bus();
    tplp_result_if result_bus();
    tplp_cfg_if    cfg_bus();

    two_pole_lowpass_multichannel dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    lowpass_scoreboard          sb = new();
    bit                         steady_flow = 1'b0;
    int                         result_wait = 0;
    int                         idle_cycles = 0;
    logic [CIU_W-1:0]           ciu_now = CIU_RST;
    logic [CHAN_W-1:0]          last_ch = '0;
    logic signed [SAMPLE_W-1:0] last_x = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait();
        return steady_flow ? 0 : int'($urandom_range(0, 5));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b1;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                sb.write_register(cfg_bus.index, cfg_bus.data);
            end
            if (item_bus.valid && item_bus.ready)
            begin
                sb.predict_item(item_bus.opcode, item_bus.channel, item_bus.sample);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                sb.compare_output(result_bus.filtered_value, result_bus.status,
                                  result_bus.channel_echo);
                result_wait = draw_wait();
                result_bus.ready <= (result_wait == 0);
            end
            else if (result_wait > 0)
            begin
                result_wait = result_wait - 1;
                result_bus.ready <= (result_wait == 0);
            end
            if ((cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready)
                || (result_bus.valid && result_bus.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL two_pole_lowpass_multichannel");
                $finish;
            end
        end
    end

    task automatic send_item(opcode_t op, logic [CHAN_W-1:0] ch,
                             logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.opcode <= op;
        item_bus.channel <= ch;
        item_bus.sample <= x;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
    endtask

    task automatic finish_items();
        item_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_outputs();
        finish_items();
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] sum, logic [CFG_DATA_W-1:0] prod,
                                 logic [CFG_DATA_W-1:0] ciu);
        write_register(REG_COEF_SUM, sum);
        write_register(REG_COEF_PROD, prod);
        write_register(REG_CHANNELS_IN_USE, ciu);
        ciu_now = ciu[CIU_W-1:0];
    endtask

    task automatic send_random_item();
        opcode_t                    op;
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] x;
        int                         pick;
        int                         live;
        live = (ciu_now == 0 || int'(ciu_now) > CHANNELS) ? CHANNELS : int'(ciu_now);
        op = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_SAMPLE;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            ch = last_ch;
        end
        else if (pick < 85)
        begin
            ch = CHAN_W'($urandom_range(0, live - 1));
        end
        else
        begin
            ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            x = last_x;
        end
        else if (pick < 50)
        begin
            x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        else if (pick < 70)
        begin
            x = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
        end
        else
        begin
            x = SAMPLE_W'($urandom);
        end
        last_ch = ch;
        last_x = x;
        send_item(op, ch, x);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] sum;
        logic [CFG_DATA_W-1:0] prod;
        logic [CFG_DATA_W-1:0] ciu;
        int                    v;

        rst_n <= 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.opcode <= OP_SAMPLE;
        item_bus.channel <= '0;
        item_bus.sample <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_COEF_SUM;
        cfg_bus.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients, one channel in use
        send_item(OP_SAMPLE, 3'd0, 16'sh7fff);
        send_item(OP_SAMPLE, 3'd0, 16'sh7fff);
        send_item(OP_SAMPLE, 3'd0, 16'sh7fff);
        send_item(OP_SAMPLE, 3'd0, 16'sh8000);
        send_item(OP_SAMPLE, 3'd0, 16'sh8000);
        send_item(OP_SAMPLE, 3'd1, 16'sd100);
        send_item(OP_SAMPLE, 3'd7, -16'sd1);
        send_item(OP_CLEAR, 3'd5, 16'sh7fff);
        send_item(OP_SAMPLE, 3'd0, 16'sd0);
        send_item(OP_SAMPLE, 3'd0, 16'sd1);
        send_item(OP_SAMPLE, 3'd0, -16'sd1);
        send_item(OP_CLEAR, 3'd0, 16'sd0);
        wait_for_outputs();

        // passthrough on all channels, spare index ignored
        write_register(REG_SPARE, '1);
        apply_setting(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(8));
        send_item(OP_SAMPLE, 3'd7, 16'sh7fff);
        send_item(OP_SAMPLE, 3'd7, 16'sh8000);
        send_item(OP_SAMPLE, 3'd3, 16'sh5555);
        send_item(OP_SAMPLE, 3'd3, 16'shaaaa);
        wait_for_outputs();

        // no channel in use
        apply_setting(CFG_DATA_W'(131072), CFG_DATA_W'(65536), CFG_DATA_W'(0));
        send_item(OP_SAMPLE, 3'd0, 16'sd1234);
        send_item(OP_SAMPLE, 3'd6, -16'sd1234);
        wait_for_outputs();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: apply_setting(CFG_DATA_W'(131072), CFG_DATA_W'(65536), CFG_DATA_W'(8));
                1: apply_setting(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(1));
                2: apply_setting(CFG_DATA_W'(COEF_SUM_RST), CFG_DATA_W'(COEF_PROD_RST),
                                 CFG_DATA_W'(8));
                3: apply_setting(CFG_DATA_W'(262143), CFG_DATA_W'(131071), CFG_DATA_W'(15));
                default:
                begin
                    sum = CFG_DATA_W'($urandom_range(0, 131072));
                    prod = CFG_DATA_W'($urandom_range(0, 65536));
                    if ($urandom_range(0, 9) == 0)
                    begin
                        v = $urandom_range(0, 7);
                        ciu = CFG_DATA_W'((v == 0) ? 0 : v + 8);
                    end
                    else
                    begin
                        ciu = CFG_DATA_W'($urandom_range(1, 8));
                    end
                    apply_setting(sum, prod, ciu);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                begin
                    steady_flow = ($urandom_range(0, 3) == 0);
                end
                send_random_item();
            end
            steady_flow = 1'b0;
            wait_for_outputs();
        end

        repeat (16) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("PASS two_pole_lowpass_multichannel");
        end
        else
        begin
            $display("FAIL two_pole_lowpass_multichannel");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tplp_pkg.sv
rtl/core/tplp_intf.sv
rtl/core/tplp_cfg_regs.sv
rtl/core/two_pole_lowpass_multichannel.sv
tb/two_pole_lowpass_multichannel_tb.sv
